// ----- rtl/aat_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aat_pkg: shared definitions for the abusive address table
// Table geometry, field widths, function and register codes, entry layout.
// ----------------------------------------------------------------------------
package aat_pkg;

  localparam int TABLE_ENTRIES = 64;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);

  localparam int ADDR_W     = 64;
  localparam int COUNT_W    = 16;
  localparam int TIME_W     = 32;
  localparam int REMOVED_W  = 7;
  localparam int IN_DATA_W  = 160;
  localparam int IN_USER_W  = 3;
  localparam int OUT_DATA_W = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;

  // function codes
  localparam logic [1:0] FUNC_CHECK  = 2'd0;
  localparam logic [1:0] FUNC_REPORT = 2'd1;
  localparam logic [1:0] FUNC_SWEEP  = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT   = 1'd1;

  localparam logic [COUNT_W-1:0]   THRESHOLD_RESET = 16'd10;
  localparam logic [TIME_W-1:0]    TIMEOUT_RESET   = 32'd3600;
  localparam logic [COUNT_W-1:0]   COUNT_MAX       = '1;
  localparam logic [COUNT_W-1:0]   COUNT_ONE       = 16'd1;
  localparam logic [REMOVED_W-1:0] REMOVED_MAX     = '1;

  // one table row as held in the memory
  typedef struct packed {
    logic               v6;
    logic [ADDR_W-1:0]  addr_high;
    logic [ADDR_W-1:0]  addr_low;
    logic [COUNT_W-1:0] count;
    logic [TIME_W-1:0]  last_seen;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // compare unit verdict on one row
  typedef struct packed {
    logic match;
    logic expired;
  } cmp_res_t;

endpackage
`default_nettype wire

// ----- rtl/aat_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aat_ram: generic simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module aat_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ----- rtl/aat_cmp.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aat_cmp: row compare unit
// Matches one table row against the search key and tests it for idle expiry.
// ----------------------------------------------------------------------------
module aat_cmp (
  input  aat_pkg::entry_t                 row,
  input  logic                            key_v6,
  input  logic [aat_pkg::ADDR_W-1:0]      key_high,
  input  logic [aat_pkg::ADDR_W-1:0]      key_low,
  input  logic [aat_pkg::TIME_W-1:0]      now,
  input  logic [aat_pkg::TIME_W-1:0]      timeout,
  output aat_pkg::cmp_res_t               res
);

  logic [aat_pkg::TIME_W-1:0] idle;

  // idle time wraps modulo 2^32
  assign idle = now - row.last_seen;

  always_comb begin
    res.match   = (row.v6 == key_v6) && (row.addr_high == key_high) &&
                  (row.addr_low == key_low);
    res.expired = idle > timeout;
  end

endmodule
`default_nettype wire

// ----- rtl/abusive_address_table_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// abusive_address_table_core: blocklist of IPv4/IPv6 addresses with aging
// Check, report and sweep transactions over a table of abusive addresses.
// ----------------------------------------------------------------------------
// Usage:
//   Input transactions arrive on s_t*: tuser carries the function (check,
//   report, sweep) and the address family, tdata the address and the time.
//   Each input produces exactly one result transaction on m_t*. Registers are
//   to be written through cfg_we/cfg_addr/cfg_wdata while idle (unenforced).
// Timing:
//   Every transaction scans the whole table through the single read port of
//   the entry memory, one row a cycle, each row judged by the one compare
//   unit; the row update follows in ST_WRITE and the result in ST_FIN. The
//   block takes no new transaction until the result is written, s_tready
//   being low from acceptance until then.
// Reset:
//   rst clears all valid marks at once (no clearing pass) and loads the
//   register defaults: threshold 10, timeout 3600.
// Back-pressure:
//   The result sits in an output register; a new transaction is taken while
//   it waits, and the block holds before writing the next result until
//   m_tready has taken the previous one.
// ----------------------------------------------------------------------------
module abusive_address_table_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [aat_pkg::CFG_IDX_W-1:0]     cfg_addr,
  input  logic [aat_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // address_high [63:0], address_low [127:64], now [159:128]
  input  logic [aat_pkg::IN_DATA_W-1:0]     s_tdata,
  // func [1:0], is_v6 [2]
  input  logic [aat_pkg::IN_USER_W-1:0]     s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // blacklisted [0], found [1], dropped_full [2], removed_count [9:3], zero [15:10]
  output logic [aat_pkg::OUT_DATA_W-1:0]    m_tdata
);

  localparam int IDX_W = aat_pkg::IDX_W;
  localparam logic [IDX_W:0] ENTRIES_CNT = (IDX_W + 1)'(aat_pkg::TABLE_ENTRIES);

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_WRITE, ST_FIN} state_t;

  state_t state;

  logic [aat_pkg::COUNT_W-1:0]   threshold;
  logic [aat_pkg::TIME_W-1:0]    timeout;
  logic [aat_pkg::TABLE_ENTRIES-1:0] entry_valid;

  // transaction registers
  logic [1:0]                    func;
  logic                          key_v6;
  logic [aat_pkg::ADDR_W-1:0]    key_high;
  logic [aat_pkg::ADDR_W-1:0]    key_low;
  logic [aat_pkg::TIME_W-1:0]    now;

  // scan registers
  logic [IDX_W:0]                rd_cnt;
  logic                          pend;
  logic [IDX_W-1:0]              pend_idx;
  logic                          hit;
  logic [IDX_W-1:0]              hit_idx;
  logic [aat_pkg::COUNT_W-1:0]   hit_count;
  logic                          free_ok;
  logic [IDX_W-1:0]              free_idx;
  logic [aat_pkg::REMOVED_W-1:0] removed;

  logic                          rd_more;
  logic                          lookup;
  logic                          do_refresh;
  logic                          do_alloc;
  logic                          row_valid;
  logic                          res_black;
  logic                          res_found;
  logic                          res_dropped;
  logic [aat_pkg::COUNT_W-1:0]   count_next;

  logic                          ram_we;
  logic [IDX_W-1:0]              ram_waddr;
  aat_pkg::entry_t               ram_wdata;
  aat_pkg::entry_t               ram_rdata;
  aat_pkg::cmp_res_t             cmp;

  assign s_tready   = (state == ST_IDLE);
  assign rd_more    = (rd_cnt != ENTRIES_CNT);
  assign lookup     = (func == aat_pkg::FUNC_CHECK) || (func == aat_pkg::FUNC_REPORT);
  assign do_refresh = lookup && hit;
  assign do_alloc   = (func == aat_pkg::FUNC_REPORT) && !hit && free_ok;
  assign row_valid  = entry_valid[pend_idx];

  assign res_black   = (func == aat_pkg::FUNC_CHECK) && hit && (hit_count > threshold);
  assign res_found   = do_refresh;
  assign res_dropped = (func == aat_pkg::FUNC_REPORT) && !hit && !free_ok;

  always_comb begin
    if (func != aat_pkg::FUNC_REPORT) begin
      count_next = hit_count;
    end else if (!hit) begin
      count_next = aat_pkg::COUNT_ONE;
    end else if (hit_count == aat_pkg::COUNT_MAX) begin
      count_next = hit_count;
    end else begin
      count_next = hit_count + 1'b1;
    end
  end

  always_comb begin
    ram_we              = (state == ST_WRITE) && (do_refresh || do_alloc);
    ram_waddr           = hit ? hit_idx : free_idx;
    ram_wdata.v6        = key_v6;
    ram_wdata.addr_high = key_high;
    ram_wdata.addr_low  = key_low;
    ram_wdata.count     = count_next;
    ram_wdata.last_seen = now;
  end

  aat_ram #(
    .WIDTH (aat_pkg::ENTRY_W),
    .DEPTH (aat_pkg::TABLE_ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (rd_cnt[IDX_W-1:0]),
    .rdata (ram_rdata)
  );

  aat_cmp u_cmp (
    .row      (ram_rdata),
    .key_v6   (key_v6),
    .key_high (key_high),
    .key_low  (key_low),
    .now      (now),
    .timeout  (timeout),
    .res      (cmp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      m_tvalid    <= 1'b0;
      pend        <= 1'b0;
      rd_cnt      <= '0;
      removed     <= '0;
      entry_valid <= '0;
      threshold   <= aat_pkg::THRESHOLD_RESET;
      timeout     <= aat_pkg::TIMEOUT_RESET;
    end else begin
      if (cfg_we) begin
        unique case (cfg_addr)
          aat_pkg::REG_THRESHOLD: threshold <= cfg_wdata[aat_pkg::COUNT_W-1:0];
          aat_pkg::REG_TIMEOUT:   timeout   <= cfg_wdata[aat_pkg::TIME_W-1:0];
        endcase
      end

      // in ST_FIN a taken result is replaced by the new one below
      if (m_tvalid && m_tready && (state != ST_FIN)) begin
        m_tvalid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            func     <= s_tuser[1:0];
            key_v6   <= s_tuser[2];
            // IPv4 keeps only the low 32 bits of the address
            key_high <= s_tuser[2] ? s_tdata[63:0] : '0;
            key_low  <= s_tuser[2] ? s_tdata[127:64] : {32'd0, s_tdata[95:64]};
            now      <= s_tdata[159:128];
            rd_cnt   <= '0;
            pend     <= 1'b0;
            hit      <= 1'b0;
            free_ok  <= 1'b0;
            removed  <= '0;
            state    <= ST_SCAN;
          end
        end

        ST_SCAN: begin
          // read issue and compare of the previous row overlap
          pend     <= rd_more;
          pend_idx <= rd_cnt[IDX_W-1:0];
          if (rd_more) begin
            rd_cnt <= rd_cnt + 1'b1;
          end
          if (pend) begin
            if (lookup && row_valid && cmp.match && !hit) begin
              hit       <= 1'b1;
              hit_idx   <= pend_idx;
              hit_count <= ram_rdata.count;
            end
            if (!row_valid && !free_ok) begin
              free_ok  <= 1'b1;
              free_idx <= pend_idx;
            end
            if ((func == aat_pkg::FUNC_SWEEP) && row_valid && cmp.expired) begin
              entry_valid[pend_idx] <= 1'b0;
              if (removed != aat_pkg::REMOVED_MAX) begin
                removed <= removed + 1'b1;
              end
            end
          end
          if (!rd_more && !pend) begin
            state <= ST_WRITE;
          end
        end

        ST_WRITE: begin
          if (do_alloc) begin
            entry_valid[free_idx] <= 1'b1;
          end
          state <= ST_FIN;
        end

        ST_FIN: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {6'd0, removed, res_dropped, res_found, res_black};
            state    <= ST_IDLE;
          end
        end

        default: state <= ST_IDLE;
      endcase
    end
  end

  // a sweep cannot remove more rows than it has read
  a_removed_bound: assert property (@(posedge clk) disable iff (rst)
    32'(removed) <= 32'(rd_cnt))
    else $error("removed count ahead of scan");

  // found and dropped exclude each other in every result
  a_result_excl: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[1] && m_tdata[2]))
    else $error("result both found and dropped");

  // an allocated row is valid once the write has happened
  a_alloc_valid: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WRITE && do_alloc) |=> entry_valid[free_idx])
    else $error("allocated row not marked valid");

  // an expired row is gone after the sweep has judged it
  a_sweep_clear: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN && pend && func == aat_pkg::FUNC_SWEEP && row_valid && cmp.expired)
    |=> !entry_valid[$past(pend_idx)])
    else $error("expired row still valid");

endmodule
`default_nettype wire
